// File: hdl/hde_pkg.sv
// shared types, codes and tables for the http date to epoch seconds block
package hde_pkg;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DAY_FIRST,
    OP_DAY_NEXT,
    OP_MON_FIRST,
    OP_MON_SECOND,
    OP_MON_THIRD,
    OP_YEAR_FIRST,
    OP_YEAR_NEXT,
    OP_YEAR_850,
    OP_HOUR_FIRST,
    OP_HOUR_NEXT,
    OP_MIN_FIRST,
    OP_MIN_NEXT,
    OP_SEC_FIRST,
    OP_SEC_NEXT
  } hde_op_t;

  typedef struct packed {
    logic is_digit;
    logic is_space;
    logic is_comma;
    logic is_dash;
    logic is_colon;
    logic is_month_lead;
  } hde_status_t;

  typedef struct packed {
    hde_op_t op;
    logic    calc1;
    logic    calc2;
    logic    calc3;
    logic    fail;
  } hde_cmd_t;

  localparam int unsigned SecsW = 39;
  localparam int unsigned DaysW = 24;

  function automatic logic [4:0] month_len(input logic [3:0] mn);
    logic [4:0] r;
    case (mn)
      4'd0:    r = 5'd31;
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd30;
      4'd4:    r = 5'd31;
      4'd5:    r = 5'd30;
      4'd6:    r = 5'd31;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd30;
      4'd9:    r = 5'd31;
      4'd10:   r = 5'd30;
      4'd11:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // month term of the march-based day count, 367 * m / 12 with m = 1 for march
  function automatic logic [8:0] month_offset(input logic [3:0] mn);
    logic [8:0] r;
    case (mn)
      4'd0:    r = 9'd336;
      4'd1:    r = 9'd367;
      4'd2:    r = 9'd30;
      4'd3:    r = 9'd61;
      4'd4:    r = 9'd91;
      4'd5:    r = 9'd122;
      4'd6:    r = 9'd152;
      4'd7:    r = 9'd183;
      4'd8:    r = 9'd214;
      4'd9:    r = 9'd244;
      4'd10:   r = 9'd275;
      4'd11:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/http_date_to_epoch_seconds_core.sv
// top level: http date string to seconds since 1970
//
//  channel  dir  handshake             payload
//  in       in   in_tvalid/in_tready   in_tdata char_byte, in_tlast last_char
//  out      out  out_tvalid/out_tready out_tdata date_error, epoch_seconds
//  cfg      in   cfg_wr_en             cfg_wr_data limit_year_2038
//
// one character a cycle while in_tready is high; in_tready drops while the last
// character's conversion runs (quotients, day count, seconds multiply, in that
// order), after which the result word is loaded
// the result register frees the input side: the next string streams in while
// the word waits, and only the final conversion step waits on out_tready
// synchronous active-low reset clears the parser, phase and limit register
module http_date_to_epoch_seconds_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] date_error, [39:1] epoch_seconds
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import hde_pkg::*;

  hde_status_t status;
  hde_cmd_t    cmd;

  hde_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  hde_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_char     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_word    (out_tdata)
  );

endmodule

// File: hdl/hde_dpath.sv
// datapath: character decode, date fields and the epoch conversion
module hde_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_char,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  hde_pkg::hde_cmd_t   cmd,
  output hde_pkg::hde_status_t status,
  output logic [39:0]         out_word
);
  import hde_pkg::*;

  logic        limit_r;
  logic [6:0]  day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [7:0]  let1_r, let2_r;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [6:0]  sec_r, sec_nxt;

  logic [3:0]  dig;
  logic [13:0] year_x10;
  logic [3:0]  mon_third;

  // conversion pipeline
  logic signed [14:0] y_r, y_c;
  logic [13:0] ypos_r, ypos_c;
  logic [7:0]  yq_r, yrq_r;
  logic [26:0] yq_prod, yrq_prod;
  logic [16:0] tod_r, tod_c;
  logic        ok1_r, ok1_c, feb29_r;
  logic        ok2_r, leap;
  logic signed [DaysW-1:0] days_r, days_c;
  logic        out_err_r;
  logic signed [SecsW-1:0] out_secs_r, secs_c;

  assign dig = in_char[3:0];
  assign status.is_digit      = (in_char >= 8'h30) && (in_char <= 8'h39);
  assign status.is_space      = (in_char == 8'h20);
  assign status.is_comma      = (in_char == 8'h2c);
  assign status.is_dash       = (in_char == 8'h2d);
  assign status.is_colon      = (in_char == 8'h3a);
  assign status.is_month_lead = (in_char == "J") || (in_char == "F") || (in_char == "M") ||
                                (in_char == "A") || (in_char == "S") || (in_char == "O") ||
                                (in_char == "N") || (in_char == "D");

  assign year_x10 = 14'({year_r, 3'b000} + {year_r, 1'b0} + 17'(dig));

  always_comb begin
    case (let1_r)
      "J":     mon_third = (let2_r == "a") ? 4'd0 : (in_char == "n") ? 4'd5 : 4'd6;
      "F":     mon_third = 4'd1;
      "M":     mon_third = (in_char == "r") ? 4'd2 : 4'd4;
      "A":     mon_third = (let2_r == "p") ? 4'd3 : 4'd7;
      "S":     mon_third = 4'd8;
      "O":     mon_third = 4'd9;
      "N":     mon_third = 4'd10;
      default: mon_third = 4'd11;
    endcase
  end

  always_comb begin
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    case (cmd.op)
      OP_DAY_FIRST:  day_nxt  = 7'(dig);
      OP_DAY_NEXT:   day_nxt  = 7'({day_r, 3'b000} + {day_r, 1'b0} + 10'(dig));
      OP_MON_THIRD:  mon_nxt  = mon_third;
      OP_YEAR_FIRST: year_nxt = 14'(dig);
      OP_YEAR_NEXT:  year_nxt = year_x10;
      OP_YEAR_850:   year_nxt = year_x10 + ((year_x10 < 14'd70) ? 14'd2000 : 14'd1900);
      OP_HOUR_FIRST: hour_nxt = 7'(dig);
      OP_HOUR_NEXT:  hour_nxt = 7'({hour_r, 3'b000} + {hour_r, 1'b0} + 10'(dig));
      OP_MIN_FIRST:  min_nxt  = 7'(dig);
      OP_MIN_NEXT:   min_nxt  = 7'({min_r, 3'b000} + {min_r, 1'b0} + 10'(dig));
      OP_SEC_FIRST:  sec_nxt  = 7'(dig);
      OP_SEC_NEXT:   sec_nxt  = 7'({sec_r, 3'b000} + {sec_r, 1'b0} + 10'(dig));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 1'b0;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    day_r  <= day_nxt;
    mon_r  <= mon_nxt;
    year_r <= year_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    if (cmd.op == OP_MON_FIRST) let1_r <= in_char;
    if (cmd.op == OP_MON_SECOND) let2_r <= in_char;
  end

  // first step: shifted year, quotients by 100, range checks
  always_comb begin
    y_c = signed'({1'b0, year_r}) - ((mon_r < 4'd2) ? 15'sd1 : 15'sd0);
    ypos_c = y_c[14] ? 14'd0 : y_c[13:0];
    yq_prod  = 27'(ypos_c) * 27'd5243;
    yrq_prod = 27'(year_r) * 27'd5243;
    tod_c = 17'(hour_r * 17'd3600) + 17'(min_r * 17'd60) + 17'(sec_r);
    ok1_c = !cmd.fail && (hour_r <= 7'd23) && (min_r <= 7'd60) && (sec_r <= 7'd60) &&
            !(limit_r && (year_r >= 14'd2038));
    if (!((day_r == 7'd29) && (mon_r == 4'd1)) && (day_r > 7'(month_len(mon_r))))
      ok1_c = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      y_r     <= y_c;
      ypos_r  <= ypos_c;
      yq_r    <= yq_prod[26:19];
      yrq_r   <= yrq_prod[26:19];
      tod_r   <= tod_c;
      ok1_r   <= ok1_c;
      feb29_r <= (day_r == 7'd29) && (mon_r == 4'd1);
    end
  end

  // second step: leap day and day count
  always_comb begin
    leap = (year_r[1:0] == 2'b00) &&
           ((year_r != 14'(yrq_r * 14'd100)) || (yrq_r[1:0] == 2'b00));
    days_c = DaysW'(y_r) * 24'sd365
           + signed'(DaysW'(ypos_r >> 2))
           - signed'(DaysW'(yq_r))
           + signed'(DaysW'(yq_r >> 2))
           + signed'(DaysW'(month_offset(mon_r)))
           + signed'(DaysW'(day_r))
           - 24'sd719499;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc2) begin
      days_r <= days_c;
      ok2_r  <= ok1_r && (!feb29_r || leap);
    end
  end

  assign secs_c = SecsW'(days_r) * 39'sd86400 + signed'(SecsW'(tod_r));

  always_ff @(posedge clk) begin
    if (cmd.calc3) begin
      out_err_r  <= !ok2_r;
      out_secs_r <= ok2_r ? secs_c : '0;
    end
  end

  assign out_word = {out_secs_r, out_err_r};

endmodule

// File: hdl/hde_ctrl.sv
// controller: parse position sequencer and conversion phases
module hde_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tlast,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  hde_pkg::hde_status_t status,
  output hde_pkg::hde_cmd_t    cmd
);
  import hde_pkg::*;

  typedef enum logic [26:0] {
    POS_WDAY = 27'h0000001, POS_SKIP = 27'h0000002, POS_D1   = 27'h0000004,
    POS_D2   = 27'h0000008, POS_DSEP = 27'h0000010, POS_M1   = 27'h0000020,
    POS_M2   = 27'h0000040, POS_M3   = 27'h0000080, POS_MSEP = 27'h0000100,
    POS_Y1   = 27'h0000200, POS_Y2   = 27'h0000400, POS_Y3   = 27'h0000800,
    POS_Y4   = 27'h0001000, POS_ISP  = 27'h0002000, POS_ID1  = 27'h0004000,
    POS_ID2  = 27'h0008000, POS_TSEP = 27'h0010000, POS_H1   = 27'h0020000,
    POS_H2   = 27'h0040000, POS_C1   = 27'h0080000, POS_MI1  = 27'h0100000,
    POS_MI2  = 27'h0200000, POS_C2   = 27'h0400000, POS_S1   = 27'h0800000,
    POS_S2   = 27'h1000000, POS_YSEP = 27'h2000000, POS_DONE = 27'h4000000
  } pos_t;

  typedef enum logic [3:0] {
    PH_PARSE = 4'b0001,
    PH_CALC1 = 4'b0010,
    PH_CALC2 = 4'b0100,
    PH_CALC3 = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    LAY_NONE = 2'd0,
    LAY_822  = 2'd1,
    LAY_850  = 2'd2,
    LAY_ISOC = 2'd3
  } layout_t;

  pos_t    pos_r, pos_nxt, pos_p, eff;
  phase_t  phase_r, phase_nxt;
  layout_t lay_r, lay_nxt, lay_p;
  logic    err_r, err_nxt, err_p;
  logic    fail_r, fail_nxt;
  logic    oval_r, oval_nxt;
  logic    take;
  logic    accept;
  logic    slot_free;
  hde_op_t op_p;

  assign in_tready = (phase_r == PH_PARSE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !oval_r || out_tready;
  assign out_tvalid = oval_r;

  // one byte of the date
  always_comb begin
    pos_p = pos_r;
    lay_p = lay_r;
    err_p = err_r;
    op_p  = OP_NONE;
    eff   = pos_r;
    take  = !err_r;
    if (pos_r == POS_SKIP) begin
      if (status.is_space) take = 1'b0;
      else eff = (lay_r == LAY_ISOC) ? POS_M1 : POS_D1;
      pos_p = eff;
    end else if (pos_r == POS_ISP) begin
      eff   = POS_ID1;
      pos_p = POS_ID1;
      if (status.is_space) take = 1'b0;
    end
    if (err_r) pos_p = pos_r;
    if (take) begin
      case (eff)
        POS_WDAY: begin
          if (status.is_comma) begin
            lay_p = LAY_NONE;
            pos_p = POS_SKIP;
          end else if (status.is_space) begin
            lay_p = LAY_ISOC;
            pos_p = POS_SKIP;
          end
        end
        POS_D1, POS_ID1: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_DAY_FIRST;
            pos_p = (eff == POS_D1) ? POS_D2 : POS_ID2;
          end
        end
        POS_D2: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_DAY_NEXT;
            pos_p = POS_DSEP;
          end
        end
        POS_DSEP: begin
          if (status.is_space) begin
            lay_p = LAY_822;
            pos_p = POS_M1;
          end else if (status.is_dash) begin
            lay_p = LAY_850;
            pos_p = POS_M1;
          end else err_p = 1'b1;
        end
        POS_M1: begin
          if (!status.is_month_lead) err_p = 1'b1;
          else begin
            op_p  = OP_MON_FIRST;
            pos_p = POS_M2;
          end
        end
        POS_M2: begin
          op_p  = OP_MON_SECOND;
          pos_p = POS_M3;
        end
        POS_M3: begin
          op_p  = OP_MON_THIRD;
          pos_p = POS_MSEP;
        end
        POS_MSEP: begin
          if ((lay_r == LAY_822 && !status.is_space) || (lay_r == LAY_850 && !status.is_dash))
            err_p = 1'b1;
          else pos_p = (lay_r == LAY_ISOC) ? POS_ISP : POS_Y1;
        end
        POS_Y1: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_YEAR_FIRST;
            pos_p = POS_Y2;
          end
        end
        POS_Y2: begin
          if (!status.is_digit) err_p = 1'b1;
          else if (lay_r == LAY_850) begin
            op_p  = OP_YEAR_850;
            pos_p = POS_TSEP;
          end else begin
            op_p  = OP_YEAR_NEXT;
            pos_p = POS_Y3;
          end
        end
        POS_Y3: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_YEAR_NEXT;
            pos_p = POS_Y4;
          end
        end
        POS_Y4: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_YEAR_NEXT;
            pos_p = (lay_r == LAY_ISOC) ? POS_DONE : POS_TSEP;
          end
        end
        POS_ID2: begin
          if (status.is_space) pos_p = POS_H1;
          else if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_DAY_NEXT;
            pos_p = POS_TSEP;
          end
        end
        POS_TSEP: begin
          if (!status.is_space) err_p = 1'b1;
          else pos_p = POS_H1;
        end
        POS_H1: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_HOUR_FIRST;
            pos_p = POS_H2;
          end
        end
        POS_H2: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_HOUR_NEXT;
            pos_p = POS_C1;
          end
        end
        POS_C1: begin
          if (!status.is_colon) err_p = 1'b1;
          else pos_p = POS_MI1;
        end
        POS_MI1: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_MIN_FIRST;
            pos_p = POS_MI2;
          end
        end
        POS_MI2: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_MIN_NEXT;
            pos_p = POS_C2;
          end
        end
        POS_C2: begin
          if (!status.is_colon) err_p = 1'b1;
          else pos_p = POS_S1;
        end
        POS_S1: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_SEC_FIRST;
            pos_p = POS_S2;
          end
        end
        POS_S2: begin
          if (!status.is_digit) err_p = 1'b1;
          else begin
            op_p  = OP_SEC_NEXT;
            pos_p = (lay_r == LAY_ISOC) ? POS_YSEP : POS_DONE;
          end
        end
        POS_YSEP: begin
          if (!status.is_space) err_p = 1'b1;
          else pos_p = POS_Y1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    lay_nxt   = lay_r;
    err_nxt   = err_r;
    fail_nxt  = fail_r;
    phase_nxt = phase_r;
    oval_nxt  = oval_r && !out_tready;
    cmd.op    = accept ? op_p : OP_NONE;
    cmd.calc1 = 1'b0;
    cmd.calc2 = 1'b0;
    cmd.calc3 = 1'b0;
    cmd.fail  = fail_r;
    case (phase_r)
      PH_PARSE: begin
        if (accept) begin
          if (in_tlast) begin
            // string ends: latch the verdict and start over for the next word
            fail_nxt  = (pos_p != POS_DONE) || err_p;
            pos_nxt   = POS_WDAY;
            lay_nxt   = LAY_NONE;
            err_nxt   = 1'b0;
            phase_nxt = PH_CALC1;
          end else begin
            pos_nxt = pos_p;
            lay_nxt = lay_p;
            err_nxt = err_p;
          end
        end
      end
      PH_CALC1: begin
        cmd.calc1 = 1'b1;
        phase_nxt = PH_CALC2;
      end
      PH_CALC2: begin
        cmd.calc2 = 1'b1;
        phase_nxt = PH_CALC3;
      end
      PH_CALC3: begin
        if (slot_free) begin
          cmd.calc3 = 1'b1;
          oval_nxt  = 1'b1;
          phase_nxt = PH_PARSE;
        end
      end
      default: phase_nxt = PH_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_WDAY;
      lay_r   <= LAY_NONE;
      err_r   <= 1'b0;
      fail_r  <= 1'b0;
      phase_r <= PH_PARSE;
      oval_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      lay_r   <= lay_nxt;
      err_r   <= err_nxt;
      fail_r  <= fail_nxt;
      phase_r <= phase_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

// File: dv/http_date_to_epoch_seconds_checker.sv
// checker: watches the date channels, predicts results and compares them
module http_date_to_epoch_seconds_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [0] date_error, [39:1] epoch_seconds
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    POS_WDAY, POS_SKIP, POS_D1, POS_D2, POS_DSEP, POS_M1, POS_M2, POS_M3, POS_MSEP,
    POS_Y1, POS_Y2, POS_Y3, POS_Y4, POS_ISP, POS_ID1, POS_ID2, POS_TSEP, POS_H1,
    POS_H2, POS_C1, POS_MI1, POS_MI2, POS_C2, POS_S1, POS_S2, POS_YSEP, POS_DONE
  } pos_t;
  typedef enum logic [1:0] {LAY_NONE, LAY_822, LAY_850, LAY_ASC} lay_t;

  typedef struct packed {
    logic [38:0] epoch_seconds;
    logic        date_error;
  } date_word_t;

  logic  limit_2038;
  pos_t  pos;
  lay_t  lay;
  int    day, mon, yr, hh, mm, ss;
  logic [7:0] mon_first, mon_second;
  logic  bad;
  date_word_t expected_dates[$];

  assign pending_count = expected_dates.size();

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_date();
    pos = POS_WDAY; lay = LAY_NONE; day = 0; mon = 0; yr = 0;
    hh = 0; mm = 0; ss = 0; mon_first = 0; mon_second = 0; bad = 0;
  endtask

  task automatic parse_char(logic [7:0] c);
    bit dg;
    int d;
    dg = is_dig(c);
    d = dg ? c - "0" : 0;
    case (pos)
      POS_WDAY: if (c == ",") begin lay = LAY_NONE; pos = POS_SKIP; end
        else if (c == " ") begin lay = LAY_ASC; pos = POS_SKIP; end
      POS_D1, POS_ID1: if (!dg) bad = 1;
        else begin day = d; pos = (pos == POS_D1) ? POS_D2 : POS_ID2; end
      POS_D2: if (!dg) bad = 1; else begin day = day * 10 + d; pos = POS_DSEP; end
      POS_DSEP: if (c == " ") begin lay = LAY_822; pos = POS_M1; end
        else if (c == "-") begin lay = LAY_850; pos = POS_M1; end
        else bad = 1;
      POS_M1: if (c inside {"J", "F", "M", "A", "S", "O", "N", "D"}) begin
          mon_first = c; mon_second = 0; pos = POS_M2;
        end else bad = 1;
      POS_M2: begin mon_second = c; pos = POS_M3; end
      POS_M3: begin
        case (mon_first)
          "J": mon = (mon_second == "a") ? 0 : (c == "n") ? 5 : 6;
          "F": mon = 1;
          "M": mon = (c == "r") ? 2 : 4;
          "A": mon = (mon_second == "p") ? 3 : 7;
          "S": mon = 8;
          "O": mon = 9;
          "N": mon = 10;
          default: mon = 11;
        endcase
        pos = POS_MSEP;
      end
      POS_MSEP: if ((lay == LAY_822 && c != " ") || (lay == LAY_850 && c != "-")) bad = 1;
        else pos = (lay == LAY_ASC) ? POS_ISP : POS_Y1;
      POS_Y1: if (!dg) bad = 1; else begin yr = d; pos = POS_Y2; end
      POS_Y2: if (!dg) bad = 1;
        else begin
          yr = yr * 10 + d;
          if (lay == LAY_850) begin
            yr += (yr < 70) ? 2000 : 1900; pos = POS_TSEP;
          end else pos = POS_Y3;
        end
      POS_Y3: if (!dg) bad = 1; else begin yr = yr * 10 + d; pos = POS_Y4; end
      POS_Y4: if (!dg) bad = 1;
        else begin yr = yr * 10 + d; pos = (lay == LAY_ASC) ? POS_DONE : POS_TSEP; end
      POS_ID2: if (c == " ") pos = POS_H1;
        else if (!dg) bad = 1;
        else begin day = day * 10 + d; pos = POS_TSEP; end
      POS_TSEP: if (c != " ") bad = 1; else pos = POS_H1;
      POS_H1: if (!dg) bad = 1; else begin hh = d; pos = POS_H2; end
      POS_MI1: if (!dg) bad = 1; else begin mm = d; pos = POS_MI2; end
      POS_S1: if (!dg) bad = 1; else begin ss = d; pos = POS_S2; end
      POS_H2: if (!dg) bad = 1; else begin hh = hh * 10 + d; pos = POS_C1; end
      POS_MI2: if (!dg) bad = 1; else begin mm = mm * 10 + d; pos = POS_C2; end
      POS_S2: if (!dg) bad = 1;
        else begin ss = ss * 10 + d; pos = (lay == LAY_ASC) ? POS_YSEP : POS_DONE; end
      POS_C1: if (c != ":") bad = 1; else pos = POS_MI1;
      POS_C2: if (c != ":") bad = 1; else pos = POS_S1;
      POS_YSEP: if (c != " ") bad = 1; else pos = POS_Y1;
      default: ;
    endcase
  endtask

  function automatic date_word_t convert_date();
    date_word_t w;
    longint y, m, days, secs;
    int mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    w = '{date_error: 1'b1, epoch_seconds: '0};
    if (pos != POS_DONE || bad) return w;
    if (hh > 23 || mm > 60 || ss > 60) return w;
    if (day == 29 && mon == 1) begin
      if ((yr % 4) != 0 || (yr % 100 == 0 && yr % 400 != 0)) return w;
    end else if (day > mlen[mon]) return w;
    if (limit_2038 && yr >= 2038) return w;
    y = yr;
    m = mon - 1;
    if (m <= 0) begin m += 12; y -= 1; end
    days = y / 4 - y / 100 + y / 400 + 367 * m / 12 + day + y * 365 - 719499;
    secs = days * 86400 + hh * 3600 + mm * 60 + ss;
    w.date_error = 0;
    w.epoch_seconds = secs[38:0];
    return w;
  endfunction

  always @(posedge clk) begin
    date_word_t got, want;
    if (!rst_n) begin
      limit_2038 <= 0;
      clear_date();
      expected_dates.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) limit_2038 <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (!bad) begin
          if (pos == POS_SKIP) begin
            if (in_tdata != " ") begin
              pos = (lay == LAY_ASC) ? POS_M1 : POS_D1;
              parse_char(in_tdata);
            end
          end else if (pos == POS_ISP) begin
            pos = POS_ID1;
            if (in_tdata != " ") parse_char(in_tdata);
          end else parse_char(in_tdata);
        end
        if (in_tlast) begin
          expected_dates.push_back(convert_date());
          clear_date();
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_dates.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected word %h", out_tdata);
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected err=%0b secs=%0d, got err=%0b secs=%0d",
                       want.date_error, $signed(want.epoch_seconds),
                       got.date_error, $signed(got.epoch_seconds));
          end
        end
      end
    end
  end
endmodule

// File: dv/tb_http_date_to_epoch_seconds_core.sv
// testbench top: date string stimulus, stalls, config phases and verdict
module tb_http_date_to_epoch_seconds_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = 0;   // [7:0] char_byte
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;      // [0] date_error, [39:1] epoch_seconds
  logic        cfg_wr_en = 0;
  logic        cfg_wr_data = 0;
  int          fail_count, pending_count;
  int          cycle_count = 0;
  int          in_idle_pct = 35, out_idle_pct = 35;
  bit          hold_out = 0;
  int          strings_sent = 0;

  http_date_to_epoch_seconds_core dut (.*);
  http_date_to_epoch_seconds_checker chk (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_out) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_char(logic [7:0] c, logic lst);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= c;
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    strings_sent++;
  endtask

  task automatic drain_and_config(logic v);
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  function automatic string two(int v);
    return $sformatf("%02d", v);
  endfunction

  function automatic string rand_date();
    string wk[4] = '{"Sun", "Monday", "Tue", "X"};
    string mn[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                      "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
    string s, t;
    int d, y, kind, k;
    d = $urandom_range(31);
    if ($urandom_range(9) == 0) d = $urandom_range(99);
    y = $urandom_range(3) == 0 ? $urandom_range(9999) : 1900 + $urandom_range(200);
    t = {two($urandom_range(3) == 0 ? $urandom_range(99) : $urandom_range(23)), ":",
         two($urandom_range(61)), ":", two($urandom_range(61))};
    kind = $urandom_range(2);
    case (kind)
      0: s = {wk[$urandom_range(3)], ", ", two(d), " ", mn[$urandom_range(11)], " ",
              $sformatf("%04d", y), " ", t};
      1: s = {wk[$urandom_range(3)], ", ", two(d), "-", mn[$urandom_range(11)], "-",
              two(y % 100), " ", t};
      default: s = {wk[$urandom_range(3)], " ", mn[$urandom_range(11)], " ",
                    (d < 10 && $urandom_range(1)) ? $sformatf(" %0d", d) : two(d),
                    " ", t, " ", $sformatf("%04d", y)};
    endcase
    if ($urandom_range(7) == 0) s = {s, " GMT"};
    // corrupt some strings: random byte or early end
    k = $urandom_range(9);
    if (k == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
    else if (k == 1) s = s.substr(0, $urandom_range(s.len() - 1));
    return s;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    send_string("Sun, 06 Nov 1994 08:49:37");
    send_string("Sunday, 06-Nov-94 08:49:37");
    send_string("Sun Nov  6 08:49:37 1994");
    send_string("Thu, 01 Jan 1970 00:00:00");
    send_string("Wed, 31 Dec 1969 23:59:60");
    send_string("x, 29 Feb 2000 23:60:60 trailing");
    send_string("x, 29 Feb 1900 00:00:00");
    send_string("x, 29 Feb 2024 00:00:00");
    send_string("x, 00 Mar 0000 00:00:00");
    send_string("x, 05 Jan 0000 00:00:00");
    send_string("x, 31 Apr 2001 24:00:00");
    send_string("x, 01-Jul-69 12:00:61");
    send_string("x, 01-Jun-70 12:00:00");
    send_string("x Aug 9 01:02:03 9999");
    send_string("x Mxy 19 01:02:03 2037");
    send_string("x, 01 Qan 2000 00:00:00");
    send_string("x, 1");
    send_string({"x, 01 Sep 2038 00:00:00", 8'hff});
    send_string({8'h00, 8'hff, 8'h80, 8'h7f});
    drain_and_config(1);
    send_string("x, 01 Oct 2037 23:59:59");
    send_string("x, 01 Oct 2038 00:00:00");
    // sender pauses, receiver holds off while strings keep coming
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    @(negedge clk);
    hold_out = 1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_out = 0;
      end
      begin
        repeat (3) send_string("Mon, 02 Dec 2030 11:11:11");
        in_tvalid <= 0;
      end
    join
    @(negedge clk);
    in_idle_pct = 0; out_idle_pct = 0;
    repeat (2) send_string(rand_date());
    in_idle_pct = 35; out_idle_pct = 35;
    for (int i = 0; i < 2; i++) begin
      if (i == 1) drain_and_config(0);
      send_string(rand_date());
    end
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// File: filelist.f
hdl/hde_pkg.sv
hdl/hde_dpath.sv
hdl/hde_ctrl.sv
hdl/http_date_to_epoch_seconds_core.sv
dv/http_date_to_epoch_seconds_checker.sv
dv/tb_http_date_to_epoch_seconds_core.sv
